@@ hw/rtl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler table package
// Shared slot record type, command codes and result status codes.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Command codes carried on in_command.
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_DISPATCH = 2'd3;

  // Status codes carried on out_status.
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DUE       = 3'd4;
  localparam logic [2:0] ST_IDLE      = 3'd5;

  // One slot of the task table as it moves around the ring.
  typedef struct packed {
    logic        valid;
    logic        ready;
    logic [15:0] delay;
    logic [15:0] period;
    logic [15:0] ident;
    logic [15:0] handle;
  } slot_t;

endpackage

@@ hw/rtl/pts_cell.sv @@
// ----------------------------------------------------------------------------
// Scheduler table cell
// Holds one task slot and takes its neighbor's slot whenever the ring shifts.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  pts_pkg::slot_t slot_in,
  output pts_pkg::slot_t slot_out
);

  logic        valid_r;
  logic        ready_r;
  logic [15:0] delay_r;
  logic [15:0] period_r;
  logic [15:0] ident_r;
  logic [15:0] handle_r;

  // Control fields clear on reset; ident and handle only matter once written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      ready_r  <= 1'b0;
      delay_r  <= '0;
      period_r <= '0;
    end else if (shift) begin
      valid_r  <= slot_in.valid;
      ready_r  <= slot_in.ready;
      delay_r  <= slot_in.delay;
      period_r <= slot_in.period;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ident_r  <= slot_in.ident;
      handle_r <= slot_in.handle;
    end
  end

  always_comb begin
    slot_out.valid  = valid_r;
    slot_out.ready  = ready_r;
    slot_out.delay  = delay_r;
    slot_out.period = period_r;
    slot_out.ident  = ident_r;
    slot_out.handle = handle_r;
  end

endmodule

@@ hw/rtl/pts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scheduler table controller
// Sequences one full rotation of the slot ring per item, edits the slot at
// the head as it passes, and produces the result items.
// ----------------------------------------------------------------------------
module pts_ctrl #(
  parameter int TASK_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_command,
  input  logic [15:0]    in_start_delay,
  input  logic [15:0]    in_repeat_period,
  input  logic [15:0]    in_task_handle,
  input  logic [15:0]    in_target_id,
  input  pts_pkg::slot_t head,
  output pts_pkg::slot_t tail,
  output logic           shift,
  output logic           out_strobe,
  output logic [2:0]     out_status,
  output logic [15:0]    out_task_id,
  output logic [15:0]    out_due_handle,
  output logic           out_last
);

  localparam int CNT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        cmd_r;
  logic [15:0]       dly_r;
  logic [15:0]       per_r;
  logic [15:0]       hnd_r;
  logic [15:0]       tgt_r;
  logic              hit_r;
  logic              hit_nxt;
  logic              due;
  logic              pend_valid_r;
  logic [15:0]       pend_id_r;
  logic [15:0]       pend_hnd_r;
  logic [15:0]       next_id_r;
  logic              out_strobe_r;
  logic [2:0]        out_status_r;
  logic [15:0]       out_task_id_r;
  logic [15:0]       out_due_handle_r;
  logic              out_last_r;

  assign busy           = (state_r != S_IDLE);
  assign shift          = (state_r == S_WALK);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_task_id    = out_task_id_r;
  assign out_due_handle = out_due_handle_r;
  assign out_last       = out_last_r;

  // Edit of the slot at the head of the ring before it re-enters at the tail.
  always_comb begin
    tail    = head;
    hit_nxt = hit_r;
    due     = 1'b0;
    case (cmd_r)
      pts_pkg::CMD_ADD: begin
        if (!hit_r && !head.valid) begin
          tail.valid  = 1'b1;
          tail.ready  = 1'b0;
          tail.delay  = dly_r;
          tail.period = per_r;
          tail.ident  = next_id_r;
          tail.handle = hnd_r;
          hit_nxt     = 1'b1;
        end
      end
      pts_pkg::CMD_DELETE: begin
        if (!hit_r && head.valid && (head.ident == tgt_r)) begin
          tail.valid = 1'b0;
          tail.ready = 1'b0;
          hit_nxt    = 1'b1;
        end
      end
      pts_pkg::CMD_TICK: begin
        if (head.valid) begin
          if (head.delay == 16'd0) begin
            tail.ready = 1'b1;
            tail.delay = head.period;
          end else begin
            tail.delay = head.delay - 16'd1;
          end
        end
      end
      pts_pkg::CMD_DISPATCH: begin
        if (head.valid && head.ready) begin
          due        = 1'b1;
          tail.ready = 1'b0;
          if (head.period == 16'd0) begin
            tail.valid = 1'b0;
          end
        end
      end
      default: begin
        tail = head;
      end
    endcase
  end

  // Sequencer, pending dispatch result and registered result port.
  // A due task is held back one find so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      hit_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      next_id_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r      <= S_WALK;
            cnt_r        <= '0;
            hit_r        <= 1'b0;
            pend_valid_r <= 1'b0;
            cmd_r        <= in_command;
            dly_r        <= in_start_delay;
            per_r        <= in_repeat_period;
            hnd_r        <= in_task_handle;
            tgt_r        <= in_target_id;
          end
        end
        S_WALK: begin
          hit_r <= hit_nxt;
          if (due) begin
            pend_valid_r <= 1'b1;
            pend_id_r    <= head.ident;
            pend_hnd_r   <= head.handle;
            if (pend_valid_r) begin
              out_strobe_r     <= 1'b1;
              out_status_r     <= pts_pkg::ST_DUE;
              out_task_id_r    <= pend_id_r;
              out_due_handle_r <= pend_hnd_r;
              out_last_r       <= 1'b0;
            end
          end
          if (cnt_r == CNT_W'(TASK_SLOTS - 1)) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          state_r          <= S_IDLE;
          out_strobe_r     <= 1'b1;
          out_last_r       <= 1'b1;
          out_task_id_r    <= '0;
          out_due_handle_r <= '0;
          case (cmd_r)
            pts_pkg::CMD_ADD: begin
              if (hit_r) begin
                out_status_r  <= pts_pkg::ST_ADDED;
                out_task_id_r <= next_id_r;
                next_id_r     <= next_id_r + 16'd1;
              end else begin
                out_status_r <= pts_pkg::ST_FULL;
              end
            end
            pts_pkg::CMD_DELETE: begin
              out_status_r <= hit_r ? pts_pkg::ST_DELETED : pts_pkg::ST_NOT_FOUND;
            end
            pts_pkg::CMD_DISPATCH: begin
              if (pend_valid_r) begin
                out_status_r     <= pts_pkg::ST_DUE;
                out_task_id_r    <= pend_id_r;
                out_due_handle_r <= pend_hnd_r;
              end else begin
                out_status_r <= pts_pkg::ST_IDLE;
              end
            end
            default: begin
              out_status_r <= pts_pkg::ST_IDLE;
            end
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/periodic_task_scheduler_table_unit.sv @@
// Results: the final result item of a command is registered in the done state
// after the walk; dispatch results before it come out during the walk.
// Commands: a new command is taken only while idle (busy low), after one full
// rotation of the slot ring through the single edit point at its head and the result state.
// Reset: synchronous, clears the valid and control fields of every slot and the ID counter.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Periodic task scheduler table
// A ring of slot cells rotates once per command past the controller, which
// adds, deletes, ticks or dispatches tasks one slot per cycle.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_table_unit #(
  parameter int TASK_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_start_delay,
  input  logic [15:0] in_repeat_period,
  input  logic [15:0] in_task_handle,
  input  logic [15:0] in_target_id,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [15:0] out_task_id,
  output logic [15:0] out_due_handle,
  output logic        out_last
);

  pts_pkg::slot_t cell_q [TASK_SLOTS];
  pts_pkg::slot_t tail;
  logic           shift;

  // Ring of slot cells: each cell takes from the next one, the last from the
  // controller's edit of the head slot.
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    pts_pkg::slot_t cell_d;
    if (i == TASK_SLOTS - 1) begin : g_tail
      assign cell_d = tail;
    end else begin : g_mid
      assign cell_d = cell_q[i+1];
    end
    pts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .slot_in  (cell_d),
      .slot_out (cell_q[i])
    );
  end

  // Command sequencer and head-slot editor.
  pts_ctrl #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_start_delay   (in_start_delay),
    .in_repeat_period (in_repeat_period),
    .in_task_handle   (in_task_handle),
    .in_target_id     (in_target_id),
    .head             (cell_q[0]),
    .tail             (tail),
    .shift            (shift),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_task_id      (out_task_id),
    .out_due_handle   (out_due_handle),
    .out_last         (out_last)
  );

endmodule
